// ===== rtl/rpm_pkg.sv =====
// shared constants, codes and control types for the rolling precision monitor
`default_nettype none
package rpm_pkg;

	localparam int WINDOW_DEPTH = 1000;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int OUT_CNT_W    = 10;
	localparam int FILL_CMP_W   = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
	localparam int Q_W          = 17;
	localparam int TIME_W       = 48;
	localparam int DEC_W        = 10;
	localparam int DIV_STEPS    = Q_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = TIME_W;

	localparam logic [Q_W-1:0]       ONE_Q16     = 17'h10000;
	localparam logic [DEC_W-1:0]     DEC_MAX     = '1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_LIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVERY_DEC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EVERY_MS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMP  = 3'd5;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_WARN   = 2'd1;
	localparam logic [1:0] ACT_DEMOTE = 2'd2;
	localparam logic [1:0] ACT_HALT   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_DIV,
		ST_EVAL
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic count;
		logic div_step;
		logic div_first;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rpm_ctrl.sv =====
// sequencing state machine: accept, count update, divide steps, evaluate
`default_nettype none
module rpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rpm_pkg::ctl_sts_t sts,
	output rpm_pkg::ctl_cmd_t cmd
);
	import rpm_pkg::*;

	ctl_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (step_q == '0);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rpm_datapath.sv =====
// window ring, counters, restoring divider, evaluation logic and result register
`default_nettype none
module rpm_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rpm_pkg::ctl_cmd_t                  cmd,
	output rpm_pkg::ctl_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [rpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               pred_flag,
	input  logic                               actual_flag,
	input  logic [rpm_pkg::TIME_W-1:0]         time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rpm_pkg::Q_W-1:0]            precision,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      true_pos_count,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      false_pos_count,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      fill_level,
	output logic [rpm_pkg::DEC_W-1:0]          since_eval,
	output logic [1:0]                         action,
	output logic                               demoted,
	output logic                               rapid_drop,
	output logic                               evaluated
);
	import rpm_pkg::*;

	// configuration
	logic [Q_W-1:0]    thr_q, margin_q, drop_lim_q;
	logic [DEC_W-1:0]  every_dec_q;
	logic [TIME_W-1:0] every_ms_q;
	logic [DEC_W-1:0]  min_samp_q;

	// request capture
	logic              pred_q, act_q;
	logic [TIME_W-1:0] now_q;

	// window state
	logic [1:0]        ring [WINDOW_DEPTH];
	logic [1:0]        old_q;
	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  fill_q, tp_q, fp_q, tot_q;
	logic [DEC_W-1:0]  dec_q;
	logic [TIME_W-1:0] last_q;
	logic [Q_W-1:0]    prior_q;
	logic [1:0]        act_reg_q;
	logic              dem_q, drop_q, trig_q;

	// divider
	logic [CNT_W-1:0]  rem_q;
	logic [Q_W-1:0]    quo_q;

	// result register
	logic              out_valid_q;
	logic [Q_W-1:0]    prec_out_q;
	logic [OUT_CNT_W-1:0] tp_out_q, fp_out_q, fill_out_q;
	logic [DEC_W-1:0]  since_out_q;
	logic [1:0]        act_out_q;
	logic              dem_out_q, drop_out_q, eval_out_q;

	// count update
	logic              full;
	logic [CNT_W-1:0]  tp_dec, fp_dec, tp_n, fp_n, fill_n;
	logic [CNT_W:0]    tot_sum;
	logic [PTR_W-1:0]  wp_n;
	logic [DEC_W-1:0]  dec_n;
	logic [TIME_W-1:0] gap;
	logic              time_trig;

	always_comb begin
		full   = (fill_q == CNT_W'(WINDOW_DEPTH));
		tp_dec = tp_q;
		fp_dec = fp_q;
		if (full && old_q[1]) begin
			if (old_q[0]) begin
				if (tp_q != '0) tp_dec = tp_q - CNT_W'(1);
			end else begin
				if (fp_q != '0) fp_dec = fp_q - CNT_W'(1);
			end
		end
		tp_n    = tp_dec + CNT_W'(pred_q & act_q);
		fp_n    = fp_dec + CNT_W'(pred_q & ~act_q);
		tot_sum = (CNT_W + 1)'(tp_n) + (CNT_W + 1)'(fp_n);
		wp_n    = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
		fill_n  = full ? fill_q : fill_q + CNT_W'(1);
		dec_n   = (dec_q == DEC_MAX) ? dec_q : dec_q + DEC_W'(1);
		gap     = now_q - last_q;
		time_trig = (now_q != '0) && (last_q != '0) && (gap >= every_ms_q);
	end

	// divide step
	logic [CNT_W:0]   r_cur, r_sub;
	logic             q_bit;
	logic [CNT_W-1:0] rem_d;

	always_comb begin
		r_cur = cmd.div_first ? {1'b0, tp_q} : {rem_q, 1'b0};
		q_bit = (r_cur >= {1'b0, tot_q});
		r_sub = r_cur - {1'b0, tot_q};
		rem_d = q_bit ? r_sub[CNT_W-1:0] : r_cur[CNT_W-1:0];
	end

	// evaluation
	logic [Q_W-1:0]   prec;
	logic [Q_W:0]     warn_lim;
	logic             enough, drop_hit, drop_nxt, dem_nxt;
	logic [1:0]       act_nxt;
	logic [Q_W-1:0]   prior_nxt;

	always_comb begin
		prec      = (tot_q == '0) ? '0 : quo_q;
		warn_lim  = {1'b0, thr_q} + {1'b0, margin_q};
		enough    = (FILL_CMP_W'(fill_q) >= FILL_CMP_W'(min_samp_q));
		drop_hit  = trig_q && enough && (prior_q != '0) && (prior_q > prec) &&
			((prior_q - prec) > drop_lim_q);
		drop_nxt  = drop_q | drop_hit;
		act_nxt   = act_reg_q;
		dem_nxt   = dem_q;
		prior_nxt = prior_q;
		if (trig_q) begin
			if (drop_hit) begin
				act_nxt = ACT_HALT;
				dem_nxt = 1'b1;
			end
			if (!drop_nxt) begin
				if (!enough) begin
					act_nxt = ACT_NONE;
					dem_nxt = 1'b0;
				end else begin
					if (prec < thr_q) begin
						act_nxt = ACT_DEMOTE;
						dem_nxt = 1'b1;
					end else if ({1'b0, prec} < warn_lim) begin
						act_nxt = ACT_WARN;
						dem_nxt = 1'b0;
					end else begin
						act_nxt = ACT_NONE;
						dem_nxt = 1'b0;
					end
					prior_nxt = prec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= Q_W'(62259);
			margin_q    <= Q_W'(1311);
			drop_lim_q  <= Q_W'(16384);
			every_dec_q <= DEC_W'(50);
			every_ms_q  <= TIME_W'(300000);
			min_samp_q  <= DEC_W'(50);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q       <= cfg_data[Q_W-1:0];
				REG_MARGIN:    margin_q    <= cfg_data[Q_W-1:0];
				REG_DROP_LIM:  drop_lim_q  <= cfg_data[Q_W-1:0];
				REG_EVERY_DEC: every_dec_q <= cfg_data[DEC_W-1:0];
				REG_EVERY_MS:  every_ms_q  <= cfg_data[TIME_W-1:0];
				REG_MIN_SAMP:  min_samp_q  <= cfg_data[DEC_W-1:0];
				default: ;
			endcase
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.count) begin
			ring[wp_q] <= {pred_q, act_q};
		end
		old_q <= ring[wp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pred_q <= pred_flag;
			act_q  <= actual_flag;
			now_q  <= time_ms;
		end
		if (cmd.count) begin
			tot_q <= tot_sum[CNT_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[Q_W-2:0], q_bit};
		end
		if (cmd.commit) begin
			prec_out_q  <= prec;
			tp_out_q    <= OUT_CNT_W'(tp_q);
			fp_out_q    <= OUT_CNT_W'(fp_q);
			fill_out_q  <= OUT_CNT_W'(fill_q);
			since_out_q <= trig_q ? '0 : dec_q;
			act_out_q   <= act_nxt;
			dem_out_q   <= dem_nxt;
			drop_out_q  <= drop_nxt;
			eval_out_q  <= trig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			tp_q        <= '0;
			fp_q        <= '0;
			dec_q       <= '0;
			last_q      <= '0;
			prior_q     <= ONE_Q16;
			act_reg_q   <= ACT_NONE;
			dem_q       <= 1'b0;
			drop_q      <= 1'b0;
			trig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.count) begin
				wp_q   <= wp_n;
				fill_q <= fill_n;
				tp_q   <= tp_n;
				fp_q   <= fp_n;
				dec_q  <= dec_n;
				trig_q <= time_trig || (dec_n >= every_dec_q);
			end
			if (cmd.commit) begin
				act_reg_q <= act_nxt;
				dem_q     <= dem_nxt;
				drop_q    <= drop_nxt;
				prior_q   <= prior_nxt;
				if (trig_q) begin
					dec_q  <= '0;
					last_q <= now_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free    = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign precision       = prec_out_q;
	assign true_pos_count  = tp_out_q;
	assign false_pos_count = fp_out_q;
	assign fill_level      = fill_out_q;
	assign since_eval      = since_out_q;
	assign action          = act_out_q;
	assign demoted         = dem_out_q;
	assign rapid_drop      = drop_out_q;
	assign evaluated       = eval_out_q;

endmodule
`default_nettype wire

// ===== rtl/rolling_precision_monitor.sv =====
// top level of the rolling precision monitor
// Each decision request holds the block through the accepting cycle, a count
// update of the window counts and ring, the restoring divider that forms
// tp*65536/(tp+fp) one quotient bit per cycle, and an evaluation state at whose
// end the result is loaded. The evaluation state repeats while the result
// register still holds a result that has not been taken. A new request is
// taken as soon as the previous one is loaded into the result register, even
// if that result has not been taken yet. Configuration writes land at once;
// the window needs no clearing pass after reset.
`default_nettype none
module rolling_precision_monitor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               pred_flag,
	input  logic                               actual_flag,
	input  logic [rpm_pkg::TIME_W-1:0]         time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rpm_pkg::Q_W-1:0]            precision,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      true_pos_count,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      false_pos_count,
	output logic [rpm_pkg::OUT_CNT_W-1:0]      fill_level,
	output logic [rpm_pkg::DEC_W-1:0]          since_eval,
	output logic [1:0]                         action,
	output logic                               demoted,
	output logic                               rapid_drop,
	output logic                               evaluated
);
	import rpm_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	rpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpm_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.pred_flag          (pred_flag),
		.actual_flag        (actual_flag),
		.time_ms            (time_ms),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.precision          (precision),
		.true_pos_count     (true_pos_count),
		.false_pos_count    (false_pos_count),
		.fill_level         (fill_level),
		.since_eval         (since_eval),
		.action             (action),
		.demoted            (demoted),
		.rapid_drop         (rapid_drop),
		.evaluated          (evaluated)
	);

endmodule
`default_nettype wire

// ===== rtl/rpm_checker.sv =====
// port-level assertions for the rolling precision monitor, bound to the top level
`default_nettype none
module rpm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rpm_pkg::Q_W-1:0]       precision,
	input logic [rpm_pkg::DEC_W-1:0]     since_eval,
	input logic [1:0]                    action,
	input logic                          demoted,
	input logic                          rapid_drop,
	input logic                          evaluated
);
	import rpm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(precision) && $stable(action))
		else $error("result changed while stalled");

	a_eval_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evaluated |-> since_eval == '0)
		else $error("evaluation did not clear decision count");

	a_halt_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_HALT) |-> demoted && rapid_drop)
		else $error("halt without demote and drop flags");

	a_prec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (precision <= ONE_Q16) && (!rapid_drop || action == ACT_HALT ||
			!evaluated || demoted || action != ACT_DEMOTE))
		else $error("precision out of range");

endmodule

bind rolling_precision_monitor rpm_checker u_rpm_checker (.*);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench for the rolling precision monitor: directed and random requests against a scoreboard

typedef struct packed {
	logic [rpm_pkg::Q_W-1:0]       precision;
	logic [rpm_pkg::OUT_CNT_W-1:0] true_pos_count;
	logic [rpm_pkg::OUT_CNT_W-1:0] false_pos_count;
	logic [rpm_pkg::OUT_CNT_W-1:0] fill_level;
	logic [rpm_pkg::DEC_W-1:0]     since_eval;
	logic [1:0]                    action;
	logic                          demoted;
	logic                          rapid_drop;
	logic                          evaluated;
} report_t;

class precision_tracker;
	bit [1:0] ring [rpm_pkg::WINDOW_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned fill = 0;
	int unsigned tp = 0;
	int unsigned fp = 0;
	int unsigned since = 0;
	int unsigned prior_prec = rpm_pkg::ONE_Q16;
	logic [rpm_pkg::TIME_W-1:0] last_eval_ms = '0;
	logic [1:0] action_now = rpm_pkg::ACT_NONE;
	bit demoted_now = 1'b0;
	bit halted = 1'b0;

	int unsigned threshold = 62259;
	int unsigned margin = 1311;
	int unsigned drop_limit = 16384;
	int unsigned every_dec = 50;
	logic [rpm_pkg::TIME_W-1:0] every_ms = 48'd300000;
	int unsigned min_fill = 50;

	report_t pending_reports[$];
	int unsigned noted = 0;
	int unsigned checked = 0;
	int unsigned mismatches = 0;
	int unsigned evaluations = 0;
	int unsigned warnings = 0;
	int unsigned demotions = 0;

	function void set_register(logic [rpm_pkg::CFG_IDX_W-1:0] idx,
			logic [rpm_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			rpm_pkg::REG_THRESHOLD: threshold = 32'(value[16:0]);
			rpm_pkg::REG_MARGIN:    margin = 32'(value[16:0]);
			rpm_pkg::REG_DROP_LIM:  drop_limit = 32'(value[16:0]);
			rpm_pkg::REG_EVERY_DEC: every_dec = 32'(value[9:0]);
			rpm_pkg::REG_EVERY_MS:  every_ms = value[47:0];
			rpm_pkg::REG_MIN_SAMP:  min_fill = 32'(value[9:0]);
			default: ;
		endcase
	endfunction

	function void note_decision(logic pred, logic act, logic [rpm_pkg::TIME_W-1:0] now);
		report_t want;
		bit [1:0] old_pair;
		logic [rpm_pkg::TIME_W-1:0] elapsed;
		int unsigned prec;
		bit fire;
		bit enough;
		old_pair = ring[wr_ptr];
		// oldest request leaves the counts once the window is full
		if (fill >= rpm_pkg::WINDOW_DEPTH && old_pair[1]) begin
			if (old_pair[0] && tp > 0)
				tp--;
			else if (!old_pair[0] && fp > 0)
				fp--;
		end
		ring[wr_ptr] = {pred, act};
		if (pred && act)
			tp++;
		else if (pred)
			fp++;
		wr_ptr = (wr_ptr + 1) % rpm_pkg::WINDOW_DEPTH;
		if (fill < rpm_pkg::WINDOW_DEPTH)
			fill++;
		if (since < rpm_pkg::DEC_MAX)
			since++;
		prec = ((tp + fp) == 0) ? 0 : (tp * rpm_pkg::ONE_Q16) / (tp + fp);
		elapsed = now - last_eval_ms;
		fire = (now != 0 && last_eval_ms != 0 && elapsed >= every_ms) || (since >= every_dec);
		if (fire) begin
			enough = fill >= min_fill;
			if (enough && prior_prec != 0 && prior_prec > prec
					&& (prior_prec - prec) > drop_limit) begin
				halted = 1'b1;
				action_now = rpm_pkg::ACT_HALT;
				demoted_now = 1'b1;
			end
			if (!halted) begin
				if (!enough) begin
					action_now = rpm_pkg::ACT_NONE;
					demoted_now = 1'b0;
				end else begin
					if (prec < threshold) begin
						action_now = rpm_pkg::ACT_DEMOTE;
						demoted_now = 1'b1;
					end else if (prec < threshold + margin) begin
						action_now = rpm_pkg::ACT_WARN;
						demoted_now = 1'b0;
					end else begin
						action_now = rpm_pkg::ACT_NONE;
						demoted_now = 1'b0;
					end
					prior_prec = prec;
				end
			end
			since = 0;
			last_eval_ms = now;
		end
		want.precision = rpm_pkg::Q_W'(prec);
		want.true_pos_count = rpm_pkg::OUT_CNT_W'(tp);
		want.false_pos_count = rpm_pkg::OUT_CNT_W'(fp);
		want.fill_level = rpm_pkg::OUT_CNT_W'(fill);
		want.since_eval = rpm_pkg::DEC_W'(since);
		want.action = action_now;
		want.demoted = demoted_now;
		want.rapid_drop = halted;
		want.evaluated = fire;
		pending_reports.push_back(want);
		noted++;
	endfunction

	function string describe(report_t r);
		return $sformatf({"prec=%0d tp=%0d fp=%0d fill=%0d since=%0d",
			" action=%0d dem=%0b drop=%0b eval=%0b"},
			r.precision, r.true_pos_count, r.false_pos_count, r.fill_level, r.since_eval,
			r.action, r.demoted, r.rapid_drop, r.evaluated);
	endfunction

	function void check_report(report_t got);
		report_t want;
		string diffs;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with no request pending: %s", describe(got));
			return;
		end
		want = pending_reports.pop_front();
		checked++;
		if (want.evaluated)
			evaluations++;
		if (want.action == rpm_pkg::ACT_WARN)
			warnings++;
		if (want.action == rpm_pkg::ACT_DEMOTE)
			demotions++;
		diffs = "";
		if (got.precision !== want.precision)
			diffs = {diffs, " precision"};
		if (got.true_pos_count !== want.true_pos_count)
			diffs = {diffs, " true_pos_count"};
		if (got.false_pos_count !== want.false_pos_count)
			diffs = {diffs, " false_pos_count"};
		if (got.fill_level !== want.fill_level)
			diffs = {diffs, " fill_level"};
		if (got.since_eval !== want.since_eval)
			diffs = {diffs, " since_eval"};
		if (got.action !== want.action)
			diffs = {diffs, " action"};
		if (got.demoted !== want.demoted)
			diffs = {diffs, " demoted"};
		if (got.rapid_drop !== want.rapid_drop)
			diffs = {diffs, " rapid_drop"};
		if (got.evaluated !== want.evaluated)
			diffs = {diffs, " evaluated"};
		if (diffs != "") begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d differs in%s\n  expected %s\n  actual   %s",
					checked, diffs, describe(want), describe(got));
		end
	endfunction
endclass

module tb;
	import rpm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic [TIME_W-1:0] MS_MAX = '1;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  pred_flag = 1'b0;
	logic                  actual_flag = 1'b0;
	logic [TIME_W-1:0]     time_ms = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [Q_W-1:0]        precision;
	logic [OUT_CNT_W-1:0]  true_pos_count;
	logic [OUT_CNT_W-1:0]  false_pos_count;
	logic [OUT_CNT_W-1:0]  fill_level;
	logic [DEC_W-1:0]      since_eval;
	logic [1:0]            action;
	logic                  demoted;
	logic                  rapid_drop;
	logic                  evaluated;

	precision_tracker tracker = new();
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int pred_pct = 100;
	int true_pct = 100;
	int unsigned cycles = 0;
	logic [TIME_W-1:0] clock_ms = 48'd1;
	logic [TIME_W-1:0] gap_ms = 48'd300000;

	rolling_precision_monitor dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("rolling_precision_monitor regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready)
			tracker.note_decision(pred_flag, actual_flag, time_ms);
		if (arst_n && out_valid && out_ready)
			tracker.check_report({precision, true_pos_count, false_pos_count, fill_level,
				since_eval, action, demoted, rapid_drop, evaluated});
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	function automatic void set_idle(idle_mode_t mode);
		sender_idle_pct = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 33 : 0;
		receiver_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 33 : 0;
	endfunction

	task automatic send_decision(input logic pred, input logic act,
			input logic [TIME_W-1:0] stamp);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		pred_flag <= pred;
		actual_flag <= act;
		time_ms <= stamp;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		while (tracker.pending_reports.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	task automatic configure(input int unsigned thr, input int unsigned margin,
			input int unsigned drop, input int unsigned every_dec,
			input logic [TIME_W-1:0] every_ms, input int unsigned min_fill);
		drain_pending();
		write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
		write_register(REG_MARGIN, CFG_DATA_W'(margin));
		write_register(REG_DROP_LIM, CFG_DATA_W'(drop));
		write_register(REG_EVERY_DEC, CFG_DATA_W'(every_dec));
		write_register(REG_EVERY_MS, every_ms);
		write_register(REG_MIN_SAMP, CFG_DATA_W'(min_fill));
		cfg_we <= 1'b0;
		gap_ms = every_ms;
	endtask

	task automatic send_random_decision();
		logic [TIME_W-1:0] stamp;
		case ($urandom_range(0, 19))
			0: stamp = '0;
			1: begin
				clock_ms = TIME_W'({$urandom, $urandom});
				stamp = clock_ms;
			end
			2: begin
				clock_ms = MS_MAX - TIME_W'($urandom_range(0, 3000));
				stamp = clock_ms;
			end
			3, 4: begin
				clock_ms = clock_ms + gap_ms - TIME_W'(1) + TIME_W'($urandom_range(0, 2));
				stamp = clock_ms;
			end
			default: begin
				clock_ms = clock_ms + TIME_W'($urandom_range(0, 2000));
				stamp = clock_ms;
			end
		endcase
		send_decision($urandom_range(0, 99) < pred_pct, $urandom_range(0, 99) < true_pct, stamp);
	endtask

	task automatic run_phase(input idle_mode_t mode, input int count);
		set_idle(mode);
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				pred_pct = ($urandom_range(0, 2) == 0) ? 50 : 100;
				case ($urandom_range(0, 5))
					0: true_pct = 0;
					1: true_pct = 50;
					2: true_pct = 90;
					3: true_pct = 95;
					4: true_pct = 98;
					default: true_pct = 100;
				endcase
			end
			send_random_decision();
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every request evaluates, timestamps at the extremes
		configure(62259, 1311, 65536, 0, MS_MAX, 0);
		send_decision(1'b1, 1'b1, MS_MAX);
		send_decision(1'b1, 1'b0, 48'd1);
		send_decision(1'b0, 1'b1, 48'h8000_0000_0000);
		send_decision(1'b1, 1'b1, 48'h5555_5555_5555);
		send_decision(1'b1, 1'b0, 48'hAAAA_AAAA_AAAA);
		send_decision(1'b0, 1'b0, 48'd0);

		// time trigger blocked by a zero stamp, then fired across the wrap
		configure(62259, 1311, 65536, 3, 48'd10, 0);
		send_decision(1'b1, 1'b1, MS_MAX - 4);
		send_decision(1'b0, 1'b0, 48'd7);
		send_decision(1'b1, 1'b1, MS_MAX - 4);
		send_decision(1'b1, 1'b1, 48'd5);
		send_decision(1'b0, 1'b1, 48'd14);
		send_decision(1'b1, 1'b0, 48'd0);
		send_decision(1'b1, 1'b1, 48'd15);

		configure(62259, 1311, 65536, 50, 48'd300000, 50);
		run_phase(IDLE_NONE, 210);

		configure(58982, 6554, 65536, 10, 48'd5000, 100);
		hold_request = 400;
		run_phase(IDLE_SENDER, 210);

		configure(0, 0, 65536, 1, 48'd1, 0);
		run_phase(IDLE_RECEIVER, 100);
		drain_pending();
		run_phase(IDLE_RECEIVER, 110);

		configure(131071, 131071, 65536, 1023, MS_MAX, 1023);
		run_phase(IDLE_BOTH, 210);

		configure($urandom_range(45000, 65536), $urandom_range(0, 10000), 65536,
			$urandom_range(1, 64), TIME_W'($urandom_range(1, 20000)), $urandom_range(0, 1000));
		run_phase(IDLE_SENDER, 210);

		configure(65536, 65536, 65536, 7, 48'd2000, 1000);
		run_phase(IDLE_NONE, 210);

		// clean stretch then a collapse of precision to raise the halt
		configure(62259, 1311, 4000, 100, MS_MAX, 0);
		set_idle(IDLE_RECEIVER);
		pred_pct = 100;
		true_pct = 100;
		for (int n = 0; n < 260; n++) begin
			if (n == 130)
				true_pct = 0;
			send_random_decision();
		end

		// halt must hold through any later setting
		configure(0, 0, 0, 0, 48'd0, 0);
		run_phase(IDLE_BOTH, 160);

		drain_pending();
		$display("%0d requests, %0d results checked, %0d evaluations, %0d warnings, %0d demotions",
			tracker.noted, tracker.checked, tracker.evaluations, tracker.warnings,
			tracker.demotions);
		$display("settings from zero to full scale, window and timestamp wrap, sticky halt %s",
			tracker.halted ? "reached" : "not reached");
		if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
			$display("rolling_precision_monitor regression: pass");
		else
			$display("rolling_precision_monitor regression: fail");
		$finish;
	end
endmodule
